/* rtl/stq_pkg.sv */
// shared types, constants, compare and id conversion helpers for the sorted timeout queue
package stq_pkg;

   localparam int DEPTH = 16;
   localparam int ID_WIDTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef logic [31:0] time_type;
   typedef logic [ID_WIDTH-1:0] id_type;
   typedef logic [CNT_W-1:0] count_type;

   // operation codes carried on req_op
   typedef enum logic [2:0] {
      OP_CHECK      = 3'd0,
      OP_SET        = 3'd1,
      OP_CANCEL     = 3'd2,
      OP_CANCEL_ALL = 3'd3,
      OP_FORCE      = 3'd4
   } op_type;

   // what each cell tests its entry against
   typedef enum logic [1:0] {
      MATCH_LATER   = 2'd0,
      MATCH_EXPIRED = 2'd1,
      MATCH_ID      = 2'd2
   } match_type;

   // control word broadcast to every cell of the row
   typedef struct packed {
      match_type mode;
      logic      insert;
      logic      remove;
      time_type  key_dl;
      id_type    key_id;
   } cell_ctrl_type;

   // a strictly later than b, wrap-safe
   function automatic logic later(time_type a, time_type b);
      time_type d;
      d = a - b;
      return (d != '0) && !d[31];
   endfunction

   // port id (16 bits) to stored id, modulo 2^ID_WIDTH
   function automatic id_type to_id(logic [15:0] v);
      logic [31:0] w;
      w = {16'b0, v};
      return w[ID_WIDTH-1:0];
   endfunction

   // stored id back to the 16-bit port field
   function automatic logic [15:0] from_id(id_type v);
      logic [31:0] w;
      w = 32'(v);
      return w[15:0];
   endfunction

endpackage

/* rtl/stq_cell.sv */
// one queue slot: holds a deadline and id, tests it and shifts with its neighbors
module stq_cell import stq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  logic          at_end,
   input  logic          found_in,
   input  time_type      left_dl,
   input  id_type        left_id,
   input  time_type      right_dl,
   input  id_type        right_id,
   output logic          found_out,
   output logic          first,
   output time_type      dl_ff,
   output id_type        id_ff
);

   logic     pred;
   time_type dl_in;
   id_type   id_in;

   // per-entry test selected by the operation
   always_comb begin
      case (ctrl.mode)
         MATCH_LATER:   pred = later(dl_ff, ctrl.key_dl);
         MATCH_EXPIRED: pred = later(ctrl.key_dl, dl_ff);
         MATCH_ID:      pred = (id_ff == ctrl.key_id);
         default:       pred = 1'b0;
      endcase
   end

   // priority chain along the row
   assign first     = occupied & pred & ~found_in;
   assign found_out = found_in | (occupied & pred);

   // insert opens a gap at the first later entry, remove closes the first match
   always_comb begin
      dl_in = dl_ff;
      id_in = id_ff;
      if (ctrl.insert) begin
         if (first || (at_end && !found_in)) begin
            dl_in = ctrl.key_dl;
            id_in = ctrl.key_id;
         end else if (found_in) begin
            dl_in = left_dl;
            id_in = left_id;
         end
      end else if (ctrl.remove && found_out) begin
         dl_in = right_dl;
         id_in = right_id;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff <= dl_in;
      id_ff <= id_in;
   end

endmodule

/* rtl/sorted_timeout_queue_unit.sv */
// top level: command sequencer, row of queue cells and result word register
//
// Holds up to DEPTH timeouts (deadline, callback id) in a row of cells kept
// in deadline order; equal deadlines keep arrival order. A request word is
// taken while idle and then worked off: set, cancel all and unknown ops go
// straight to their status word (a zero-delay set first gives its fired
// word); check, cancel and force remove their matching entries and then give
// the status word, since the row pulls out exactly one matching entry per
// cycle through its priority chain unless a result word waits on rsp_ready.
// A new request is taken as soon as the status word of the previous one
// sits in the output register.
module sorted_timeout_queue_unit import stq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_delay_ms,
   input  logic [15:0] req_callback_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_fired_id,
   output logic        rsp_hit,
   output logic        rsp_next_valid,
   output logic [31:0] rsp_remaining_ms,
   output logic        rsp_overflow,
   output logic        rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [2:0]    op_ff;
   time_type      now_ff, delay_ff;
   id_type        id_ff;
   count_type     count_ff, count_in;
   logic          hit_ff, hit_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [15:0]   rsp_fired_id_ff, rsp_fired_id_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic          rsp_next_valid_ff, rsp_next_valid_in;
   logic [31:0]   rsp_remaining_ms_ff, rsp_remaining_ms_in;
   logic          rsp_overflow_ff, rsp_overflow_in;
   logic          rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   logic          accept, slot_free, step, found_any, load, done, full;
   logic          [DEPTH:0] found;
   logic          [DEPTH-1:0] first;
   time_type      cell_dl [DEPTH];
   id_type        cell_id [DEPTH];
   id_type        first_id;

   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign step      = (state_ff == ST_RUN) && slot_free;
   assign full      = (count_ff >= count_type'(DEPTH));
   assign found[0]  = 1'b0;
   assign found_any = found[DEPTH];

   // broadcast control for the cell row
   always_comb begin
      ctrl.key_id = id_ff;
      ctrl.insert = step && (op_ff == OP_SET) && (delay_ff != '0) && !full;
      ctrl.remove = step && found_any &&
                    ((op_ff == OP_CHECK) || (op_ff == OP_CANCEL) || (op_ff == OP_FORCE));
      case (op_ff)
         OP_SET: begin
            ctrl.mode   = MATCH_LATER;
            ctrl.key_dl = now_ff + delay_ff;
         end
         OP_CHECK: begin
            ctrl.mode   = MATCH_EXPIRED;
            ctrl.key_dl = now_ff;
         end
         default: begin
            ctrl.mode   = MATCH_ID;
            ctrl.key_dl = now_ff;
         end
      endcase
   end

   // row of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      time_type l_dl, r_dl;
      id_type   l_id, r_id;
      if (i == 0) begin : g_left_end
         assign l_dl = ctrl.key_dl;
         assign l_id = ctrl.key_id;
      end else begin : g_left
         assign l_dl = cell_dl[i-1];
         assign l_id = cell_id[i-1];
      end
      if (i == DEPTH - 1) begin : g_right_end
         assign r_dl = cell_dl[i];
         assign r_id = cell_id[i];
      end else begin : g_right
         assign r_dl = cell_dl[i+1];
         assign r_id = cell_id[i+1];
      end
      stq_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (count_ff > count_type'(i)),
         .at_end    (count_ff == count_type'(i)),
         .found_in  (found[i]),
         .left_dl   (l_dl),
         .left_id   (l_id),
         .right_dl  (r_dl),
         .right_id  (r_id),
         .found_out (found[i+1]),
         .first     (first[i]),
         .dl_ff     (cell_dl[i]),
         .id_ff     (cell_id[i])
      );
   end

   // id of the first matching entry
   always_comb begin
      first_id = '0;
      for (int i = 0; i < DEPTH; i++) begin
         first_id = first_id | (first[i] ? cell_id[i] : '0);
      end
   end

   // result word selection and sequencing
   always_comb begin
      load                = 1'b0;
      done                = 1'b0;
      rsp_kind_in         = 1'b1;
      rsp_fired_id_in     = '0;
      rsp_hit_in          = 1'b0;
      rsp_next_valid_in   = 1'b0;
      rsp_remaining_ms_in = '0;
      rsp_overflow_in     = 1'b0;
      rsp_last_in         = 1'b1;
      count_in            = count_ff;
      hit_in              = hit_ff;
      if (step) begin
         case (op_ff)
            OP_CHECK, OP_FORCE, OP_CANCEL: begin
               if (found_any) begin
                  hit_in   = 1'b1;
                  count_in = count_ff - count_type'(1);
                  if (op_ff != OP_CANCEL) begin
                     load            = 1'b1;
                     rsp_kind_in     = 1'b0;
                     rsp_last_in     = 1'b0;
                     rsp_fired_id_in = from_id(first_id);
                  end
               end else begin
                  load = 1'b1;
                  done = 1'b1;
                  if (op_ff == OP_CHECK) begin
                     rsp_next_valid_in = (count_ff != '0);
                     if (count_ff != '0) begin
                        rsp_remaining_ms_in = cell_dl[0] - now_ff;
                     end
                  end else begin
                     rsp_hit_in = hit_ff;
                  end
               end
            end
            OP_SET: begin
               load = 1'b1;
               if ((delay_ff == '0) && !hit_ff) begin
                  hit_in          = 1'b1;
                  rsp_kind_in     = 1'b0;
                  rsp_last_in     = 1'b0;
                  rsp_fired_id_in = from_id(id_ff);
               end else begin
                  done            = 1'b1;
                  rsp_overflow_in = (delay_ff != '0) && full;
                  if (ctrl.insert) begin
                     count_in = count_ff + count_type'(1);
                  end
               end
            end
            OP_CANCEL_ALL: begin
               load       = 1'b1;
               done       = 1'b1;
               rsp_hit_in = (count_ff != '0);
               count_in   = '0;
            end
            default: begin
               load = 1'b1;
               done = 1'b1;
            end
         endcase
      end
      if (accept) begin
         hit_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RUN;
         ST_RUN:  if (done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request and result word registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         now_ff   <= req_now_ms;
         delay_ff <= req_delay_ms;
         id_ff    <= to_id(req_callback_id);
      end
      if (load) begin
         rsp_kind_ff         <= rsp_kind_in;
         rsp_fired_id_ff     <= rsp_fired_id_in;
         rsp_hit_ff          <= rsp_hit_in;
         rsp_next_valid_ff   <= rsp_next_valid_in;
         rsp_remaining_ms_ff <= rsp_remaining_ms_in;
         rsp_overflow_ff     <= rsp_overflow_in;
         rsp_last_ff         <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_fired_id     = rsp_fired_id_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_next_valid   = rsp_next_valid_ff;
   assign rsp_remaining_ms = rsp_remaining_ms_ff;
   assign rsp_overflow     = rsp_overflow_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef SYNTH
   // entry count stays within the row
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(DEPTH))
      else $error("entry count beyond depth");

   // a fired word is never the last word of an operation
   a_fired_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> !rsp_last)
      else $error("fired word marked last");

   // a removal takes out exactly one entry
   a_remove_one: assert property (@(posedge clock) disable iff (reset)
      ctrl.remove |=> (count_ff == $past(count_ff) - count_type'(1)))
      else $error("removal did not drop one entry");

   // an insertion adds exactly one entry
   a_insert_one: assert property (@(posedge clock) disable iff (reset)
      ctrl.insert |=> (count_ff == $past(count_ff) + count_type'(1)))
      else $error("insertion did not add one entry");

   // insert and remove never happen together
   a_no_insert_remove: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.insert && ctrl.remove))
      else $error("insert and remove in one cycle");
`endif

endmodule
